### design/ipv6ck_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ipv6ck_pkg;

	// Length of the fixed IPv6 header that the pseudo-header replaces.
	localparam int unsigned HdrLen = 40;

	// Width of the saturating byte position counter (holds 0 to HdrLen).
	localparam int unsigned PosW = 6;

	// Positions inside the fixed header that get special treatment.
	localparam logic [PosW-1:0] PosLastDropped = PosW'(3);
	localparam logic [PosW-1:0] PosLenHigh     = PosW'(4);
	localparam logic [PosW-1:0] PosLenLow      = PosW'(5);
	localparam logic [PosW-1:0] PosNextHdr     = PosW'(6);
	localparam logic [PosW-1:0] PosHopLimit    = PosW'(7);
	localparam logic [PosW-1:0] PosHdrEnd      = PosW'(HdrLen);
	localparam logic [PosW-1:0] PosHdrLast     = PosW'(HdrLen - 1);

	// Configuration values of the mode register.
	localparam logic ModePlain = 1'b0;
	localparam logic ModeIpv6  = 1'b1;

	// Width of the ones'-complement sum and of one packet byte.
	localparam int unsigned SumW  = 16;
	localparam int unsigned ByteW = 8;

endpackage

`default_nettype wire

### design/ipv6_internet_checksum.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                               Direction  Moves
// input     in_valid, in_stall, data_byte,        in         one packet byte per request
//           is_last
// output    out_valid, out_stall, checksum,       out        one checksum per packet
//           too_short
// config    cfg_we, cfg_wdata                     in         mode register write
//
// Each byte waits in the input register and then passes through the 16-bit
// end-around-carry adder into the sum; a new byte can be accepted in every cycle
// unless a last byte waits on a stalled result. The checksum request loads into the
// result register at the edge at which its last byte leaves the input register.
// Reset clears the sum, the position, the mode and all valid flags.
// A stalled result only blocks a last byte behind it; other bytes keep flowing.
module ipv6_internet_checksum (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Configuration port for the mode register.
	input  wire logic                              cfg_we,
	input  wire logic                              cfg_wdata,
	// Byte stream.
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [ipv6ck_pkg::ByteW-1:0]      data_byte,
	input  wire logic                              is_last,
	// Checksum results.
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [ipv6ck_pkg::SumW-1:0]            checksum,
	output logic                                   too_short
);

	// Mode register.
	logic mode_q;

	// Input register.
	logic                           valid_s1;
	logic [ipv6ck_pkg::ByteW-1:0]   byte_s1;
	logic                           last_s1;

	// Running packet state.
	logic [ipv6ck_pkg::SumW-1:0]    sum_q;
	logic [ipv6ck_pkg::PosW-1:0]    pos_q;
	logic                           odd_q;

	// Result register.
	logic                           out_valid_q;
	logic [ipv6ck_pkg::SumW-1:0]    checksum_q;
	logic                           too_short_q;

	logic                           out_free;
	logic                           consume_s1;
	logic                           accept_in;
	logic                           in_hdr;
	logic                           use_byte;
	logic                           high_byte;
	logic [ipv6ck_pkg::SumW-1:0]    word;
	logic [ipv6ck_pkg::SumW:0]      sum_wide;
	logic [ipv6ck_pkg::SumW-1:0]    sum_fold;
	logic [ipv6ck_pkg::SumW-1:0]    sum_next;

	// The result register can take a new checksum when it is empty or being drained.
	assign out_free   = !out_valid_q || !out_stall;
	// Bytes that are not last never need the result register.
	assign consume_s1 = valid_s1 && (!last_s1 || out_free);
	assign in_stall   = valid_s1 && !consume_s1;
	assign accept_in  = in_valid && !in_stall;

	// Pick where the byte lands in its 16-bit word. In IPv6 mode the fixed header
	// is mapped onto the pseudo-header: the version, class, flow label and hop
	// limit are dropped, the payload length keeps its word, and the next header
	// value becomes a low byte.
	always_comb begin
		in_hdr    = (mode_q == ipv6ck_pkg::ModeIpv6) && (pos_q < ipv6ck_pkg::PosHdrEnd);
		use_byte  = 1'b1;
		high_byte = !odd_q;
		if (in_hdr) begin
			if (pos_q <= ipv6ck_pkg::PosLastDropped || pos_q == ipv6ck_pkg::PosHopLimit) begin
				use_byte = 1'b0;
			end else if (pos_q == ipv6ck_pkg::PosLenHigh) begin
				high_byte = 1'b1;
			end else if (pos_q == ipv6ck_pkg::PosLenLow || pos_q == ipv6ck_pkg::PosNextHdr) begin
				high_byte = 1'b0;
			end
		end
		word     = high_byte ? {byte_s1, {ipv6ck_pkg::ByteW{1'b0}}}
		                     : {{ipv6ck_pkg::ByteW{1'b0}}, byte_s1};
		// End-around carry: the fold cannot carry again.
		sum_wide = {1'b0, sum_q} + {1'b0, word};
		sum_fold = sum_wide[ipv6ck_pkg::SumW-1:0]
		           + {{(ipv6ck_pkg::SumW-1){1'b0}}, sum_wide[ipv6ck_pkg::SumW]};
		sum_next = use_byte ? sum_fold : sum_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ipv6ck_pkg::ModePlain;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// Input register: payload loads only with a request, so no reset is needed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (consume_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			byte_s1 <= data_byte;
			last_s1 <= is_last;
		end
	end

	// Packet state: the last byte clears everything for the next packet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			pos_q <= '0;
			odd_q <= 1'b0;
		end else if (consume_s1) begin
			if (last_s1) begin
				sum_q <= '0;
				pos_q <= '0;
				odd_q <= 1'b0;
			end else begin
				sum_q <= sum_next;
				odd_q <= !odd_q;
				if (pos_q < ipv6ck_pkg::PosHdrEnd) begin
					pos_q <= pos_q + ipv6ck_pkg::PosW'(1);
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume_s1 && last_s1) begin
			checksum_q  <= ~sum_next;
			// The packet is short when its last byte comes before the final header byte.
			too_short_q <= (mode_q == ipv6ck_pkg::ModeIpv6) && (pos_q < ipv6ck_pkg::PosHdrLast);
		end
	end

	assign out_valid = out_valid_q;
	assign checksum  = checksum_q;
	assign too_short = too_short_q;

endmodule

`default_nettype wire

### design/ipv6ck_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ipv6ck_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          cfg_we,
	input wire logic                          cfg_wdata,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic [ipv6ck_pkg::ByteW-1:0]  data_byte,
	input wire logic                          is_last,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [ipv6ck_pkg::SumW-1:0]   checksum,
	input wire logic                          too_short
);

	// Shadow of the mode register, rebuilt from the configuration port.
	logic mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ipv6ck_pkg::ModePlain;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// A stalled checksum request holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(checksum) && $stable(too_short))
		else $error("stalled checksum changed");

	// No result is shown while reset is applied.
	assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	// The byte stream is only held back by a stalled result.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	// Plain mode never flags a short packet.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (mode_q == ipv6ck_pkg::ModePlain) |-> !too_short)
		else $error("too_short set in plain mode");

	// A stalled byte request keeps its payload until it is accepted.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(data_byte) && $stable(is_last))
		else $error("stalled byte request changed");

endmodule

bind ipv6_internet_checksum ipv6ck_checker u_ipv6ck_checker (.*);

`default_nettype wire
